>>> hw/rtl/longest_match_lexer_with_symbol_tables_unit_defines.svh
// assertion macros used by the lexer controller
// depends on nothing
`ifndef LONGEST_MATCH_LEXER_WITH_SYMBOL_TABLES_UNIT_DEFINES_SVH
`define LONGEST_MATCH_LEXER_WITH_SYMBOL_TABLES_UNIT_DEFINES_SVH
// property that holds whenever reset is released
`define LML_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define LML_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`endif

>>> hw/rtl/lml_pkg.sv
// shared types, token codes and character class helpers for the lexer
// depends on nothing
`default_nettype none
package lml_pkg;
  localparam int MaxEntries = 64;
  localparam int MaxTokenLen = 16;
  localparam logic [7:0] EndMark = 8'd35;

  localparam logic [2:0] ClsKeyword = 3'd0;
  localparam logic [2:0] ClsOperator = 3'd1;
  localparam logic [2:0] ClsDelim = 3'd2;
  localparam logic [2:0] ClsIdent = 3'd3;
  localparam logic [2:0] ClsNumber = 3'd4;

  // command from controller to datapath
  typedef struct packed {
    logic load;       // latch the input byte
    logic append;     // append latched byte to pending
    logic restart;    // pending := latched byte
    logic clear;      // pending := empty
    logic scan_start; // reset the table scan pointer
    logic scan_step;  // advance the scan pointer
    logic store;      // intern pending into its table
    logic emit;       // load the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_end;
    logic is_space;
    logic can_append;
    logic pend_empty;
    logic fixed_hit;
    logic is_word;
    logic is_digits;
    logic scan_done;
    logic scan_hit;
    logic out_busy;
  } stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/lml_if.sv
// valid/ready channel interfaces for the lexer input and token output
// depends on nothing
`default_nettype none
interface lml_in_if;
  logic valid;
  logic ready;
  logic [7:0] char_code;
  modport source(output valid, output char_code, input ready);
  modport sink(input valid, input char_code, output ready);
endinterface

interface lml_out_if;
  logic valid;
  logic ready;
  logic [2:0] token_class;
  logic [5:0] token_index;
  logic table_full;
  logic stream_end;
  modport source(output valid, output token_class, output token_index,
                 output table_full, output stream_end, input ready);
  modport sink(input valid, input token_class, input token_index,
               input table_full, input stream_end, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lml_datapath.sv
// pending token buffer, symbol table memories, scan pointer and output register
// depends on lml_pkg
`default_nettype none
module lml_datapath #(
  parameter int MAX_ENTRIES = lml_pkg::MaxEntries,
  parameter int MAX_TOKEN_LEN = lml_pkg::MaxTokenLen
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [7:0] in_byte,
  input  wire lml_pkg::cmd_t cmd,
  input  wire logic end_flag,
  input  wire logic out_ready,
  output lml_pkg::stat_t stat,
  output logic copy_busy,
  output logic out_valid,
  output logic [2:0] out_class,
  output logic [5:0] out_index,
  output logic out_full,
  output logic out_end
);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int PW = $clog2(MAX_TOKEN_LEN);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = EW + PW;

  logic [7:0] byte_r;
  logic [MAX_TOKEN_LEN-1:0][7:0] pend_r;
  logic [LW-1:0] plen_r;
  logic [CW-1:0] icount_r, ncount_r;
  logic [CW-1:0] scan_r;
  logic [PW-1:0] cidx_r;
  logic cmp_ok_r;
  logic hit_r;
  logic [EW-1:0] hit_idx_r;
  logic use_num_r;

  // symbol memories: one byte per cycle, row-major
  logic [7:0] imem [2**MW];
  logic [7:0] nmem [2**MW];
  logic [LW-1:0] ilen [MAX_ENTRIES];
  logic [LW-1:0] nlen [MAX_ENTRIES];
  logic [7:0] rd_r;
  logic [LW-1:0] rlen_r;

  logic out_valid_r;
  logic [2:0] cls_r;
  logic [5:0] idx_r;
  logic full_r, end_r;

  // candidate shape checks
  logic [MAX_TOKEN_LEN-1:0][7:0] cand;
  logic [LW:0] clen;
  logic word_ok, dig_ok, word_cur, dig_cur;
  logic fx_hit;
  logic [2:0] fx_cls;
  logic [3:0] fx_idx;

  function automatic logic text_is(input logic [MAX_TOKEN_LEN-1:0][7:0] s,
                                   input logic [LW:0] n, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c,
                                   input logic [7:0] d, input logic [7:0] e,
                                   input logic [7:0] f, input int k);
    logic [5:0][7:0] t;
    logic ok;
    t = {f, e, d, c, b, a};
    ok = (n == (LW+1)'(k));
    for (int i = 0; i < 6; i++)
      if (i < k && s[i] != t[i]) ok = 1'b0;
    return ok;
  endfunction

  // classify text s of length n against the fixed lists
  function automatic logic [7:0] fixed_lookup(input logic [MAX_TOKEN_LEN-1:0][7:0] s,
                                              input logic [LW:0] n);
    logic [7:0] r;
    r = '0;
    if (text_is(s, n, "i", "n", "t", 0, 0, 0, 3)) r = {1'b1, lml_pkg::ClsKeyword, 4'd0};
    else if (text_is(s, n, "m", "a", "i", "n", 0, 0, 4))
      r = {1'b1, lml_pkg::ClsKeyword, 4'd1};
    else if (text_is(s, n, "r", "e", "t", "u", "r", "n", 6))
      r = {1'b1, lml_pkg::ClsKeyword, 4'd2};
    else if (text_is(s, n, "+", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsOperator, 4'd0};
    else if (text_is(s, n, "*", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsOperator, 4'd1};
    else if (text_is(s, n, "=", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsOperator, 4'd2};
    else if (text_is(s, n, "+", "=", 0, 0, 0, 0, 2)) r = {1'b1, lml_pkg::ClsOperator, 4'd3};
    else if (text_is(s, n, "*", "=", 0, 0, 0, 0, 2)) r = {1'b1, lml_pkg::ClsOperator, 4'd4};
    else if (text_is(s, n, "(", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsDelim, 4'd0};
    else if (text_is(s, n, ")", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsDelim, 4'd1};
    else if (text_is(s, n, "{", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsDelim, 4'd2};
    else if (text_is(s, n, "}", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsDelim, 4'd3};
    else if (text_is(s, n, ",", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsDelim, 4'd4};
    else if (text_is(s, n, ";", 0, 0, 0, 0, 0, 1)) r = {1'b1, lml_pkg::ClsDelim, 4'd5};
    return r;
  endfunction

  logic [7:0] fx_cand, fx_cur;

  always_comb begin
    cand = pend_r;
    if (plen_r < LW'(MAX_TOKEN_LEN)) cand[plen_r[PW-1:0]] = byte_r;
    clen = {1'b0, plen_r} + 1'b1;
    // running shape of the pending text plus byte
    word_cur = (plen_r != '0) && lml_pkg::is_letter(pend_r[0]);
    dig_cur = (plen_r != '0);
    for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
      if (i < plen_r) begin
        if (i > 0 && !lml_pkg::is_letter(pend_r[i]) && !lml_pkg::is_digit(pend_r[i]))
          word_cur = 1'b0;
        if (!lml_pkg::is_digit(pend_r[i])) dig_cur = 1'b0;
      end
    end
    word_ok = (plen_r == '0) ? lml_pkg::is_letter(byte_r)
            : word_cur && (lml_pkg::is_letter(byte_r) || lml_pkg::is_digit(byte_r));
    dig_ok = ((plen_r == '0) || dig_cur) && lml_pkg::is_digit(byte_r);
    fx_cand = fixed_lookup(cand, clen);
    fx_cur = fixed_lookup(pend_r, {1'b0, plen_r});
    fx_hit = fx_cur[7];
    fx_cls = fx_cur[6:4];
    fx_idx = fx_cur[3:0];
  end

  assign stat.is_end = byte_r == lml_pkg::EndMark;
  assign stat.is_space = lml_pkg::is_space(byte_r);
  assign stat.can_append = (plen_r < LW'(MAX_TOKEN_LEN)) &&
    ((fx_cand[7] && fx_cand[6:4] != lml_pkg::ClsKeyword) || word_ok || dig_ok);
  assign stat.pend_empty = plen_r == '0;
  assign stat.fixed_hit = fx_hit;
  assign stat.is_word = word_cur;
  assign stat.is_digits = dig_cur;
  assign stat.scan_hit = hit_r;
  assign stat.out_busy = out_valid_r;

  // scan: identifier table first, then numbers; each byte compare waits for its registered memory read
  logic [CW-1:0] cur_count;
  logic byte_last;
  assign cur_count = use_num_r ? ncount_r : icount_r;
  assign stat.scan_done = hit_r || (use_num_r && scan_r >= ncount_r);
  assign byte_last = ({1'b0, cidx_r} + 1'b1) >= (PW+1)'(plen_r) || cidx_r == PW'(MAX_TOKEN_LEN-1);

  logic [MW-1:0] raddr;
  assign raddr = {scan_r[EW-1:0], cidx_r};

  always_ff @(posedge clk) begin
    rd_r <= use_num_r ? nmem[raddr] : imem[raddr];
    rlen_r <= use_num_r ? nlen[scan_r[EW-1:0]] : ilen[scan_r[EW-1:0]];
  end

  // pipeline: the address is set while phase_r is low and the registered data is compared while it is high
  logic phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      icount_r <= '0;
      ncount_r <= '0;
      out_valid_r <= 1'b0;
      hit_r <= 1'b0;
      scan_r <= '0;
      cidx_r <= '0;
      phase_r <= 1'b0;
      use_num_r <= 1'b0;
      cmp_ok_r <= 1'b1;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load) byte_r <= in_byte;
      if (cmd.append) begin
        pend_r[plen_r[PW-1:0]] <= byte_r;
        plen_r <= plen_r + 1'b1;
      end
      if (cmd.restart) begin
        pend_r[0] <= byte_r;
        plen_r <= LW'(1);
      end
      if (cmd.clear) plen_r <= '0;
      if (cmd.scan_start) begin
        scan_r <= '0;
        cidx_r <= '0;
        phase_r <= 1'b0;
        hit_r <= 1'b0;
        cmp_ok_r <= 1'b1;
        use_num_r <= 1'b0;
      end else if (cmd.scan_step && !stat.scan_done) begin
        if (scan_r >= cur_count || scan_r >= CW'(MAX_ENTRIES)) begin
          use_num_r <= 1'b1;
          scan_r <= '0;
          cidx_r <= '0;
          phase_r <= 1'b0;
          cmp_ok_r <= 1'b1;
        end else if (!phase_r) begin
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (byte_last) begin
            if (cmp_ok_r && rd_r == pend_r[cidx_r] && rlen_r == plen_r) begin
              hit_r <= 1'b1;
              hit_idx_r <= scan_r[EW-1:0];
            end else begin
              scan_r <= scan_r + 1'b1;
            end
            cidx_r <= '0;
            cmp_ok_r <= 1'b1;
          end else begin
            cmp_ok_r <= cmp_ok_r && rd_r == pend_r[cidx_r];
            cidx_r <= cidx_r + 1'b1;
          end
        end
      end
      if (cmd.store) begin
        if (word_cur && icount_r < CW'(MAX_ENTRIES)) icount_r <= icount_r + 1'b1;
        else if (!word_cur && ncount_r < CW'(MAX_ENTRIES)) ncount_r <= ncount_r + 1'b1;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
    end
  end

  // interning copies the pending text one byte per cycle via cidx_r-independent counter
  logic [PW:0] cp_r;
  logic copying_r;
  logic cp_num_r;
  logic [EW-1:0] cp_row_r;
  logic [LW-1:0] plen_sv_r;
  logic [MAX_TOKEN_LEN-1:0][7:0] pend_sv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copying_r <= 1'b0;
      cp_r <= '0;
    end else if (cmd.store) begin
      copying_r <= (word_cur ? icount_r : ncount_r) < CW'(MAX_ENTRIES);
      cp_num_r <= !word_cur;
      cp_row_r <= (word_cur ? icount_r[EW-1:0] : ncount_r[EW-1:0]);
      cp_r <= '0;
    end else if (copying_r) begin
      if (cp_r + 1'b1 >= (PW+1)'(plen_sv_r)) copying_r <= 1'b0;
      cp_r <= cp_r + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      plen_sv_r <= plen_r;
      pend_sv_r <= pend_r;
    end
  end
  always_ff @(posedge clk) begin
    if (copying_r) begin
      if (cp_num_r) nmem[{cp_row_r, cp_r[PW-1:0]}] <= pend_sv_r[cp_r[PW-1:0]];
      else imem[{cp_row_r, cp_r[PW-1:0]}] <= pend_sv_r[cp_r[PW-1:0]];
    end
    if (cmd.store) begin
      if (word_cur && icount_r < CW'(MAX_ENTRIES)) ilen[icount_r[EW-1:0]] <= plen_r;
      else if (!word_cur && ncount_r < CW'(MAX_ENTRIES)) nlen[ncount_r[EW-1:0]] <= plen_r;
    end
  end
  assign copy_busy = copying_r;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      end_r <= end_flag;
      full_r <= 1'b0;
      if (fx_hit) begin
        cls_r <= fx_cls;
        idx_r <= 6'(fx_idx);
      end else if (hit_r) begin
        cls_r <= use_num_r ? lml_pkg::ClsNumber : lml_pkg::ClsIdent;
        idx_r <= 6'(hit_idx_r);
      end else begin
        cls_r <= word_cur ? lml_pkg::ClsIdent : lml_pkg::ClsNumber;
        if ((word_cur ? icount_r : ncount_r) >= CW'(MAX_ENTRIES)) begin
          full_r <= 1'b1;
          idx_r <= '0;
        end else begin
          idx_r <= 6'(word_cur ? icount_r : ncount_r);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_class = cls_r;
  assign out_index = idx_r;
  assign out_full = full_r;
  assign out_end = end_r;
endmodule
`default_nettype wire

>>> hw/rtl/lml_ctrl.sv
// controller state machine sequencing byte intake, table scan and token emission
// depends on lml_pkg and the defines header
`default_nettype none
`include "longest_match_lexer_with_symbol_tables_unit_defines.svh"
module lml_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire lml_pkg::stat_t stat,
  input  wire logic copy_busy,
  output lml_pkg::cmd_t cmd,
  output logic end_flag
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN = 6'b000100,
    S_EMIT = 6'b001000,
    S_AFTER = 6'b010000,
    S_COPY = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic end_r, end_nxt;
  logic tail_r, tail_nxt; // restart with byte after flush

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    end_nxt = end_r;
    tail_nxt = tail_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !copy_busy;
        if (in_valid && !copy_busy) begin
          cmd.load = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        end_nxt = stat.is_end;
        tail_nxt = !(stat.is_end || stat.is_space);
        if (!stat.is_end && !stat.is_space && stat.can_append) begin
          cmd.append = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.pend_empty ||
                     (!stat.fixed_hit && !stat.is_word && !stat.is_digits)) begin
          state_nxt = S_AFTER;
        end else if (stat.fixed_hit) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (!stat.fixed_hit && !stat.scan_hit) begin
            cmd.store = 1'b1;
            state_nxt = S_COPY;
          end else begin
            state_nxt = S_AFTER;
          end
        end
      end
      S_COPY: state_nxt = S_AFTER;
      S_AFTER: begin
        if (tail_r) cmd.restart = 1'b1;
        else cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      end_r <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r <= end_nxt;
      tail_r <= tail_nxt;
    end
  end
  assign end_flag = end_r;

  `LML_ASSERT(a_one_edit, !(cmd.append && (cmd.restart || cmd.clear)), "pending edit clash")
  `LML_ASSERT(a_emit_free, cmd.emit |-> !stat.out_busy, "emit over full output")
  `LML_ASSERT(a_take_idle, in_ready |-> state_r == S_IDLE, "ready outside idle")
  `LML_ASSERT_NEXT(a_load_decide, cmd.load, state_r == S_DECIDE, "load not followed by decide")
endmodule
`default_nettype wire

>>> hw/rtl/longest_match_lexer_with_symbol_tables_unit.sv
// Longest-match lexer: one byte per request, one token result at most per byte.
// A byte that extends the pending token passes through the idle and decide states.
// A flush that must look up the identifier and number tables walks the stored
// entries byte by byte through the table memory read port, each byte read before it
// is compared; interning a new symbol then copies the pending text into memory byte
// by byte, and no new byte is taken until that copy is done.
// Depends on lml_pkg, lml_if, lml_ctrl and lml_datapath.
`default_nettype none
module longest_match_lexer_with_symbol_tables_unit #(
  parameter int MAX_ENTRIES = lml_pkg::MaxEntries,
  parameter int MAX_TOKEN_LEN = lml_pkg::MaxTokenLen
) (
  input wire logic clk,
  input wire logic rst_n,
  lml_in_if.sink in_ch,
  lml_out_if.source out_ch
);
  lml_pkg::cmd_t cmd;
  lml_pkg::stat_t stat;
  logic end_flag;
  logic copy_busy;

  lml_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .stat,
    .copy_busy, .cmd, .end_flag
  );

  lml_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_dp (
    .clk, .rst_n, .in_byte(in_ch.char_code), .cmd, .end_flag,
    .out_ready(out_ch.ready), .stat, .copy_busy, .out_valid(out_ch.valid),
    .out_class(out_ch.token_class), .out_index(out_ch.token_index),
    .out_full(out_ch.table_full), .out_end(out_ch.stream_end)
  );
endmodule
`default_nettype wire

>>> tb/tb_longest_match_lexer_with_symbol_tables_unit.sv
// testbench for the longest-match lexer: random and directed byte streams,
// tokens checked against a behavioral scanner with its own symbol tables
// depends on lml_pkg, lml_if and longest_match_lexer_with_symbol_tables_unit
`default_nettype none
module tb_longest_match_lexer_with_symbol_tables_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 40000000;
  localparam int DrainCycles = 5000;
  localparam logic [7:0] Blank = 8'd32;

  typedef logic [7:0] text_t[$];
  typedef struct {
    logic [2:0] cls;
    logic [5:0] idx;
    logic full;
    logic at_end;
  } token_t;

  logic clk, rst_n;
  lml_in_if in_ch();
  lml_out_if out_ch();

  longest_match_lexer_with_symbol_tables_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  string kw_l[3] = '{"int", "main", "return"};
  string op_l[5] = '{"+", "*", "=", "+=", "*="};
  string dl_l[6] = '{"(", ")", "{", "}", ",", ";"};

  // scanner state
  text_t pending;
  text_t ident_tab[$];
  text_t number_tab[$];
  token_t tokens_due[$];
  logic [7:0] char_fifo[$];
  string name_pool[$];

  int idle_pct, stall_pct, mismatches;
  int rx_cyc;
  bit hold_send;
  longint cyc;

  function automatic bit same_txt(text_t s, string t);
    if (s.size() != t.len()) return 0;
    for (int i = 0; i < s.size(); i++)
      if (s[i] != t[i]) return 0;
    return 1;
  endfunction

  function automatic bit same_seq(text_t a, text_t b);
    if (a.size() != b.size()) return 0;
    foreach (a[i]) if (a[i] != b[i]) return 0;
    return 1;
  endfunction

  function automatic int find_list(text_t s, int which);
    if (which == 0) begin
      foreach (kw_l[i]) if (same_txt(s, kw_l[i])) return i;
    end else if (which == 1) begin
      foreach (op_l[i]) if (same_txt(s, op_l[i])) return i;
    end else begin
      foreach (dl_l[i]) if (same_txt(s, dl_l[i])) return i;
    end
    return -1;
  endfunction

  function automatic bit word_like(text_t s);
    if (s.size() == 0 || !lml_pkg::is_letter(s[0])) return 0;
    for (int i = 1; i < s.size(); i++)
      if (!lml_pkg::is_letter(s[i]) && !lml_pkg::is_digit(s[i])) return 0;
    return 1;
  endfunction

  function automatic bit digits_like(text_t s);
    if (s.size() == 0) return 0;
    foreach (s[i]) if (!lml_pkg::is_digit(s[i])) return 0;
    return 1;
  endfunction

  function automatic void flush_pending(bit at_end);
    token_t t;
    int f;
    text_t s;
    s = pending;
    pending.delete();
    if (s.size() == 0) return;
    t.full = 0;
    t.at_end = at_end;
    f = -1;
    if ((f = find_list(s, 0)) >= 0) t.cls = lml_pkg::ClsKeyword;
    else if ((f = find_list(s, 1)) >= 0) t.cls = lml_pkg::ClsOperator;
    else if ((f = find_list(s, 2)) >= 0) t.cls = lml_pkg::ClsDelim;
    else begin
      foreach (ident_tab[i]) if (f < 0 && same_seq(ident_tab[i], s)) f = i;
      if (f >= 0) t.cls = lml_pkg::ClsIdent;
      else begin
        foreach (number_tab[i]) if (f < 0 && same_seq(number_tab[i], s)) f = i;
        if (f >= 0) t.cls = lml_pkg::ClsNumber;
        else if (word_like(s)) begin
          t.cls = lml_pkg::ClsIdent;
          if (ident_tab.size() >= lml_pkg::MaxEntries) begin
            t.full = 1; f = 0;
          end else begin
            f = ident_tab.size(); ident_tab.push_back(s);
          end
        end else if (digits_like(s)) begin
          t.cls = lml_pkg::ClsNumber;
          if (number_tab.size() >= lml_pkg::MaxEntries) begin
            t.full = 1; f = 0;
          end else begin
            f = number_tab.size(); number_tab.push_back(s);
          end
        end else return;  // stray byte is dropped
      end
    end
    t.idx = f[5:0];
    tokens_due.push_back(t);
  endfunction

  function automatic void lex_char(logic [7:0] c);
    text_t cand;
    if (c == lml_pkg::EndMark) begin
      flush_pending(1);
      return;
    end
    if (lml_pkg::is_space(c)) begin
      flush_pending(0);
      return;
    end
    if (pending.size() < lml_pkg::MaxTokenLen) begin
      cand = pending;
      cand.push_back(c);
      if (find_list(cand, 1) >= 0 || find_list(cand, 2) >= 0 || word_like(cand) ||
          digits_like(cand)) begin
        pending = cand;
        return;
      end
    end
    flush_pending(0);
    pending.push_back(c);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) char_fifo.push_back(s[i]);
  endfunction

  function automatic string rand_word(int len);
    string s;
    s = "";
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) s = {s, string'(8'(48 + $urandom_range(0, 9)))};
      else if ($urandom_range(0, 1)) s = {s, string'(8'(65 + $urandom_range(0, 25)))};
      else s = {s, string'(8'(97 + $urandom_range(0, 25)))};
    end
    return s;
  endfunction

  // at most one lexeme plus an optional separator
  function automatic void gen_lexeme();
    int r;
    string s;
    r = $urandom_range(0, 99);
    if (r < 14) push_str(kw_l[$urandom_range(0, 2)]);
    else if (r < 24) push_str(op_l[$urandom_range(0, 4)]);
    else if (r < 32) push_str(dl_l[$urandom_range(0, 5)]);
    else if (r < 56) begin
      if (name_pool.size() > 0 && $urandom_range(0, 1)) s = name_pool[$urandom_range(0,
          name_pool.size() - 1)];
      else begin
        s = rand_word($urandom_range(1, 6));
        name_pool.push_back(s);
      end
      push_str(s);
    end else if (r < 74) begin
      for (int i = $urandom_range(1, 5); i > 0; i--)
        char_fifo.push_back(8'(48 + $urandom_range(0, 9)));
    end else if (r < 80) char_fifo.push_back(8'($urandom_range(0, 255)));
    else if (r < 84) char_fifo.push_back(lml_pkg::EndMark);
    else if (r < 87) push_str(rand_word($urandom_range(14, 20)));
    else if (r < 90) begin
      for (int i = $urandom_range(15, 20); i > 0; i--)
        char_fifo.push_back(8'(48 + $urandom_range(0, 9)));
    end
    r = $urandom_range(0, 9);
    if (r < 4) char_fifo.push_back(Blank);
    else if (r < 6) char_fifo.push_back(8'($urandom_range(9, 13)));
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("tb_longest_match_lexer_with_symbol_tables_unit: errors");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_ch.char_code <= 8'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) lex_char(in_ch.char_code);
      if (!in_ch.valid || in_ch.ready) begin
        if (!hold_send && char_fifo.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_ch.valid <= 1;
          in_ch.char_code <= char_fifo.pop_front();
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      rx_cyc <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc >= 3000 && rx_cyc < 3600) out_ch.ready <= 0;
      else out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // token check
  always @(posedge clk) begin
    token_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tokens_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected token class %0d index %0d", out_ch.token_class,
                   out_ch.token_index);
      end else begin
        e = tokens_due.pop_front();
        if (out_ch.token_class !== e.cls || out_ch.token_index !== e.idx ||
            out_ch.table_full !== e.full || out_ch.stream_end !== e.at_end) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("token mismatch: exp cls %0d idx %0d full %0d end %0d, got %0d %0d %0d %0d",
                     e.cls, e.idx, e.full, e.at_end, out_ch.token_class,
                     out_ch.token_index, out_ch.table_full, out_ch.stream_end);
        end
      end
    end
  end

  task automatic drain_all();
    wait (char_fifo.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (tokens_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    cyc = 0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_send = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: keywords, operators, delimiters, interning, end marker, odd bytes
    push_str("int main return += *= + * = (){},; abc 123 abc 123 ");
    char_fifo.push_back(8'hff);
    char_fifo.push_back(8'h00);
    push_str("@ x# # abcdefghijklmnopq 12345678901234567\t\n\r");
    char_fifo.push_back(lml_pkg::EndMark);

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 23 : 46) : 0;
      stall_pct = (ph == 2) ? 46 : ((ph == 3) ? 23 : 0);
      while (char_fifo.size() < 370) gen_lexeme();
      if (ph == 1) begin
        // sender waits for every token to come back
        wait (char_fifo.size() < 200);
        @(negedge clk);
        hold_send = 1;
        while (tokens_due.size() > 0 || in_ch.valid) @(posedge clk);
        @(negedge clk);
        hold_send = 0;
      end
      drain_all();
    end
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && tokens_due.size() == 0)
      $display("tb_longest_match_lexer_with_symbol_tables_unit: clean");
    else
      $display("tb_longest_match_lexer_with_symbol_tables_unit: errors");
    $finish;
  end
endmodule
`default_nettype wire
